>>> rtl/ipv4s_pkg.sv
package ipv4s_pkg;

  localparam int unsigned OCTET_W = 8;
  localparam int unsigned ADDR_W  = 4 * OCTET_W;

  typedef logic [OCTET_W-1:0] octet_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  // per-cycle command broadcast along the chain
  typedef struct packed {
    logic ins;    // insert the broadcast address
    logic drain;  // move every entry one place towards the head
  } cell_ctrl_t;

endpackage

>>> rtl/ipv4s_cell.sv
module ipv4s_cell (
  input  logic              clk,
  input  ipv4s_pkg::cell_ctrl_t ctrl,
  input  ipv4s_pkg::addr_t  addr,
  input  logic              occupied,
  input  logic              left_keep,
  input  ipv4s_pkg::addr_t  left_value,
  input  ipv4s_pkg::addr_t  right_value,
  output logic              keep,
  output ipv4s_pkg::addr_t  value
);
  import ipv4s_pkg::*;

  // an occupied entry at or above the new address stays put
  assign keep = occupied && (value >= addr);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!keep) begin
        value <= left_keep ? addr : left_value;
      end
    end else if (ctrl.drain) begin
      value <= right_value;
    end
  end

endmodule

>>> rtl/ipv4_descending_sorter.sv
// an address is in the store in the cycle after its beat is taken
// throughput: one address per cycle while filling; the cell chain inserts in one step
// on end_of_pool the run leaves one result per cycle from the head cell while
// result_stall is low; addresses are taken again in the cycle after the final beat
// reset: rst (synchronous) empties the store and clears the overflow flag
module ipv4_descending_sorter #(
  parameter int unsigned POOL_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ipv4s_pkg::octet_t octet_first,
  input  ipv4s_pkg::octet_t octet_second,
  input  ipv4s_pkg::octet_t octet_third,
  input  ipv4s_pkg::octet_t octet_fourth,
  input  logic              end_of_pool,
  output logic              result_valid,
  input  logic              result_stall,
  output ipv4s_pkg::octet_t out_first,
  output ipv4s_pkg::octet_t out_second,
  output ipv4s_pkg::octet_t out_third,
  output ipv4s_pkg::octet_t out_fourth,
  output logic              final_result,
  output logic              dropped_some
);
  import ipv4s_pkg::*;

  localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             overflow;
  logic             overflow_next;
  logic             draining;
  logic             draining_next;

  addr_t      addr;
  cell_ctrl_t ctrl;
  logic       item_beat;
  logic       result_beat;
  logic       full;
  logic       last_out;

  addr_t value [POOL_DEPTH];
  logic  keep  [POOL_DEPTH];

  assign addr        = {octet_first, octet_second, octet_third, octet_fourth};
  assign item_stall  = draining;
  assign item_beat   = item_valid && !item_stall;
  assign result_valid = draining;
  assign result_beat = result_valid && !result_stall;
  assign full        = (count == CNT_W'(POOL_DEPTH));
  assign last_out    = (count == CNT_W'(1));

  assign ctrl.ins   = item_beat && !full;
  assign ctrl.drain = result_beat;

  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    logic  occ;
    logic  lk;
    addr_t lv;
    addr_t rv;

    assign occ = (CNT_W'(i) < count);
    if (i == 0) begin : g_head
      assign lk = 1'b1;
      assign lv = addr;
    end else begin : g_body
      assign lk = keep[i-1];
      assign lv = value[i-1];
    end
    if (i == POOL_DEPTH - 1) begin : g_tail
      assign rv = value[i];
    end else begin : g_mid
      assign rv = value[i+1];
    end

    ipv4s_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .addr        (addr),
      .occupied    (occ),
      .left_keep   (lk),
      .left_value  (lv),
      .right_value (rv),
      .keep        (keep[i]),
      .value       (value[i])
    );
  end

  always_comb begin
    count_next    = count;
    overflow_next = overflow;
    draining_next = draining;
    if (item_beat) begin
      if (full) begin
        overflow_next = 1'b1;
      end else begin
        count_next = count + CNT_W'(1);
      end
      if (end_of_pool) begin
        draining_next = 1'b1;
      end
    end
    if (result_beat) begin
      count_next = count - CNT_W'(1);
      if (last_out) begin
        overflow_next = 1'b0;
        draining_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      draining <= 1'b0;
    end else begin
      count    <= count_next;
      overflow <= overflow_next;
      draining <= draining_next;
    end
  end

  // head cell is the output register during a drain
  assign out_first    = value[0][ADDR_W-1 -: OCTET_W];
  assign out_second   = value[0][ADDR_W-OCTET_W-1 -: OCTET_W];
  assign out_third    = value[0][OCTET_W*2-1 -: OCTET_W];
  assign out_fourth   = value[0][OCTET_W-1:0];
  assign final_result = last_out;
  assign dropped_some = overflow;

endmodule

>>> rtl/ipv4s_checker.sv
module ipv4s_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              end_of_pool,
  input logic              result_valid,
  input logic              result_stall,
  input ipv4s_pkg::octet_t out_first,
  input ipv4s_pkg::octet_t out_fourth,
  input logic              final_result
);
  import ipv4s_pkg::*;

  logic item_beat;
  logic result_beat;

  assign item_beat   = item_valid && !item_stall;
  assign result_beat = result_valid && !result_stall;

  // input is held off exactly while a run is going out
  a_stall_during_run: assert property (@(posedge clk) disable iff (rst)
    item_stall == result_valid)
    else $error("input stall does not track the output run");

  a_pool_end_starts_run: assert property (@(posedge clk) disable iff (rst)
    item_beat && end_of_pool |=> result_valid)
    else $error("no run after end of pool");

  a_final_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_beat && final_result |=> !result_valid)
    else $error("run continues after final beat");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    result_beat && !final_result |=> result_valid)
    else $error("run stopped before final beat");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(out_first) && $stable(out_fourth) && $stable(final_result))
    else $error("stalled result changed");

endmodule

bind ipv4_descending_sorter ipv4s_checker u_ipv4s_checker (.*);

>>> sim/testbench.sv
import ipv4s_pkg::*;

localparam int unsigned POOL_DEPTH = 64;

typedef struct {
  addr_t addr;
  logic  is_final;
  logic  dropped;
} sorted_addr_t;

// keeps its own sorted copy of the pool and the addresses it must emit
class sort_scoreboard;
  addr_t        pool [POOL_DEPTH];
  int unsigned  pool_count;
  bit           pool_overflow;
  sorted_addr_t expected_q [$];
  int unsigned  errors;

  function new();
    pool_count = 0;
    pool_overflow = 0;
    errors = 0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  task report(string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task note_beat(addr_t addr, logic eop);
    int unsigned  pos;
    sorted_addr_t ent;
    if (pool_count >= POOL_DEPTH) begin
      // store full: the address is lost whatever its value
      pool_overflow = 1;
    end else begin
      pos = 0;
      while (pos < pool_count && pool[pos] >= addr) pos++;
      for (int unsigned k = pool_count; k > pos; k--) pool[k] = pool[k-1];
      pool[pos] = addr;
      pool_count++;
    end
    if (eop) begin
      for (int unsigned k = 0; k < pool_count; k++) begin
        ent.addr = pool[k];
        ent.is_final = (k + 1 == pool_count);
        ent.dropped = pool_overflow;
        expected_q.insert(expected_q.size(), ent);
      end
      pool_count = 0;
      pool_overflow = 0;
    end
  endtask

  task check_result(octet_t o1, octet_t o2, octet_t o3, octet_t o4,
                    logic fin, logic drop);
    sorted_addr_t want_beat;
    logic [7:0]   got [6];
    logic [7:0]   want [6];
    string        field_name [6] = '{"out_first", "out_second", "out_third",
                                     "out_fourth", "final_result", "dropped_some"};
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result beat %0d.%0d.%0d.%0d", o1, o2, o3, o4));
    end else begin
      want_beat = expected_q.pop_front();
      got = '{o1, o2, o3, o4, {7'd0, fin}, {7'd0, drop}};
      want = '{want_beat.addr[31:24], want_beat.addr[23:16], want_beat.addr[15:8],
               want_beat.addr[7:0], {7'd0, want_beat.is_final},
               {7'd0, want_beat.dropped}};
      for (int i = 0; i < 6; i++) begin
        if (got[i] !== want[i])
          report($sformatf("%s got %0h want %0h", field_name[i], got[i], want[i]));
      end
    end
  endtask
endclass

module testbench;
  localparam int unsigned RESET_CYCLES = 4;
  localparam int unsigned HOLD_LONG    = 300;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned RANDOM_ITEMS = 192;

  logic   clk;
  logic   rst = 1'b1;
  logic   item_valid = 1'b0;
  logic   item_stall;
  octet_t octet_first = '0;
  octet_t octet_second = '0;
  octet_t octet_third = '0;
  octet_t octet_fourth = '0;
  logic   end_of_pool = 1'b0;
  logic   result_valid;
  logic   result_stall = 1'b1;
  octet_t out_first;
  octet_t out_second;
  octet_t out_third;
  octet_t out_fourth;
  logic   final_result;
  logic   dropped_some;

  sort_scoreboard sb = new();
  int unsigned    idle_cycles = 0;

  ipv4_descending_sorter #(.POOL_DEPTH(POOL_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .octet_first(octet_first), .octet_second(octet_second),
    .octet_third(octet_third), .octet_fourth(octet_fourth),
    .end_of_pool(end_of_pool),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_first(out_first), .out_second(out_second),
    .out_third(out_third), .out_fourth(out_fourth),
    .final_result(final_result), .dropped_some(dropped_some)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall)
        sb.note_beat({octet_first, octet_second, octet_third, octet_fourth}, end_of_pool);
      if (result_valid && !result_stall)
        sb.check_result(out_first, out_second, out_third, out_fourth,
                        final_result, dropped_some);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_address(addr_t addr, logic eop, int unsigned gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid   <= 1'b1;
    octet_first  <= addr[31:24];
    octet_second <= addr[23:16];
    octet_third  <= addr[15:8];
    octet_fourth <= addr[7:0];
    end_of_pool  <= eop;
    do @(posedge clk); while (!(item_valid && !item_stall));
  endtask

  function automatic addr_t pick_address(addr_t base);
    addr_t       a;
    int unsigned k;
    a = base;
    case ($urandom_range(0, 3))
      0: a = $urandom;
      // near duplicates of the pool base
      1: a = {base[31:8], 6'd0, 2'($urandom_range(0, 3))};
      2: begin
        case ($urandom_range(0, 3))
          0: a = 32'h0000_0000;
          1: a = 32'hffff_ffff;
          2: a = 32'h8000_0000;
          default: a = 32'h7fff_ffff;
        endcase
      end
      default: begin
        k = $urandom_range(0, 3);
        a[k*8 +: 8] = 8'($urandom_range(0, 255));
      end
    endcase
    return a;
  endfunction

  task automatic send_directed();
    addr_t dir_addr [18] = '{
      32'h0000_0000,
      32'hffff_ffff,
      32'hffff_ffff, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff,
      32'h0a00_0001, 32'h0a00_0001, 32'h0a00_0002, 32'h0102_0304,
      32'h0100_0000, 32'h0100_0001, 32'h0100_0100, 32'h0101_0000, 32'h0200_0000,
      32'hc0a8_0101, 32'hc0a8_0101, 32'hc0a8_0101};
    bit dir_eop [18] = '{1, 1, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0, 1};
    for (int i = 0; i < 18; i++)
      send_address(dir_addr[i], dir_eop[i], $urandom_range(0, 9));
  endtask

  task automatic send_random_pools();
    int unsigned sent;
    int unsigned pool_idx;
    int unsigned pool_size;
    bit          calm;
    addr_t       base;
    sent = 0;
    pool_idx = 0;
    while (sent < RANDOM_ITEMS || pool_idx <= 10) begin
      // one pool fills the store exactly, one overruns it including the end beat
      if (pool_idx == 3)
        pool_size = POOL_DEPTH;
      else if (pool_idx == 10)
        pool_size = POOL_DEPTH + 2;
      else if ($urandom_range(0, 3) == 0)
        pool_size = $urandom_range(13, 30);
      else
        pool_size = $urandom_range(1, 8);
      calm = ($urandom_range(0, 3) == 0);
      base = $urandom;
      for (int unsigned i = 0; i < pool_size; i++)
        send_address(pick_address(base), i == pool_size - 1,
                     calm ? 0 : $urandom_range(0, 9));
      sent += pool_size;
      pool_idx++;
    end
  endtask

  // receiver: starts with a long hold-off so the block backs up, another later on
  initial begin
    int unsigned taken;
    int unsigned hold;
    bit          calm;
    taken = 0;
    calm = 0;
    repeat (RESET_CYCLES + HOLD_LONG) @(posedge clk);
    result_stall <= 1'b0;
    forever begin
      do @(posedge clk); while (!(result_valid && !result_stall));
      taken++;
      if (taken % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      hold = (taken == 150) ? HOLD_LONG : (calm ? 0 : $urandom_range(0, 9));
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_directed();
    send_random_pools();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
